// ----- hdl/kped_pkg.sv -----
// Shared types, register map, reset values and event codes of the key press event detector.
`default_nettype none

package kped_pkg;

  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int KEY_W = 3;
  localparam int HELD_W = 4;
  localparam int CODE_W = 3;
  localparam int KEY_COUNT = 8;
  localparam int TIMER_BITS_DEF = 16;

  localparam logic [HELD_W-1:0] KEY_EMPTY = 4'd15;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TIME = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_REPEAT_TIME = 4'd3;

  localparam logic [CFG_W-1:0] SCAN_PERIOD_RST = 16'd10;
  localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_TIME_RST = 16'd1000;
  localparam logic [CFG_W-1:0] HOLD_REPEAT_TIME_RST = 16'd200;

  localparam logic [CODE_W-1:0] EV_NONE = 3'd0;
  localparam logic [CODE_W-1:0] EV_PRESSED = 3'd1;
  localparam logic [CODE_W-1:0] EV_RELEASED = 3'd2;
  localparam logic [CODE_W-1:0] EV_LONG_PRESSED = 3'd3;
  localparam logic [CODE_W-1:0] EV_LONG_RELEASED = 3'd4;
  localparam logic [CODE_W-1:0] EV_HOLD = 3'd5;

  typedef struct packed {
    logic [CFG_W-1:0] scan_period;
    logic [CFG_W-1:0] debounce_time;
    logic [CFG_W-1:0] long_press_time;
    logic [CFG_W-1:0] hold_repeat_time;
  } kped_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [KEY_W-1:0]  key;
  } kped_event_t;

endpackage

`default_nettype wire

// ----- hdl/kped_intf.sv -----
// Channel interfaces: key tick requests, event results and register writes.
`default_nettype none

interface kped_in_if
  import kped_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             key_active;
  logic [KEY_W-1:0] key_number;

  modport source (output valid, output key_active, output key_number, input ready);
  modport sink (input valid, input key_active, input key_number, output ready);
endinterface

interface kped_out_if
  import kped_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] event_code;
  logic [KEY_W-1:0]  event_key;

  modport source (output valid, output event_code, output event_key, input ready);
  modport sink (input valid, input event_code, input event_key, output ready);
endinterface

interface kped_cfg_if
  import kped_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/kped_cfg_regs.sv -----
// Configuration register file of the key press event detector.
`default_nettype none

module kped_cfg_regs
  import kped_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  kped_cfg_if.sink   cfg,
  output kped_cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.scan_period      <= SCAN_PERIOD_RST;
      regs.debounce_time    <= DEBOUNCE_TIME_RST;
      regs.long_press_time  <= LONG_PRESS_TIME_RST;
      regs.hold_repeat_time <= HOLD_REPEAT_TIME_RST;
    end else if (cfg.valid) begin
      // drop writes to unmapped indexes
      unique case (cfg.index)
        REG_SCAN_PERIOD:      regs.scan_period      <= cfg.data;
        REG_DEBOUNCE_TIME:    regs.debounce_time    <= cfg.data;
        REG_LONG_PRESS_TIME:  regs.long_press_time  <= cfg.data;
        REG_HOLD_REPEAT_TIME: regs.hold_repeat_time <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/kped_engine.sv -----
// Scan timer, wait timer and press state machine; one tick per cycle while tick is high.
`default_nettype none

module kped_engine
  import kped_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick,
  input  wire logic             key_active,
  input  wire logic [KEY_W-1:0] key_number,
  input  kped_cfg_t             regs,
  output kped_event_t           result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEBOUNCE = 2'd1;
  localparam logic [1:0] ST_PRESSED = 2'd2;
  localparam logic [1:0] ST_LONG = 2'd3;

  // saturate a register value to the timer range
  function automatic logic [TIMER_BITS-1:0] clamp_time(input logic [CFG_W-1:0] v);
    logic [CFG_W+TIMER_BITS-1:0] w;
    w = {{TIMER_BITS{1'b0}}, v};
    if (|w[CFG_W+TIMER_BITS-1:TIMER_BITS]) begin
      return '1;
    end
    return w[TIMER_BITS-1:0];
  endfunction

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [HELD_W-1:0]     held_key;
  logic [HELD_W-1:0]     held_key_next;
  logic [TIMER_BITS-1:0] scan_counter;
  logic [TIMER_BITS-1:0] scan_counter_next;
  logic [TIMER_BITS-1:0] wait_counter;
  logic [TIMER_BITS-1:0] wait_counter_next;

  logic [TIMER_BITS-1:0] wait_dec;
  logic [TIMER_BITS-1:0] scan_inc;
  logic [TIMER_BITS-1:0] scan_limit;
  logic [TIMER_BITS-1:0] debounce_t;
  logic [TIMER_BITS-1:0] long_t;
  logic [TIMER_BITS-1:0] hold_t;
  logic                  do_scan;
  logic                  key_ok;
  logic [HELD_W-1:0]     sample;

  assign scan_limit = clamp_time(regs.scan_period);
  assign debounce_t = clamp_time(regs.debounce_time);
  assign long_t     = clamp_time(regs.long_press_time);
  assign hold_t     = clamp_time(regs.hold_repeat_time);

  assign wait_dec = (wait_counter != '0) ? wait_counter - 1'b1 : wait_counter;
  assign scan_inc = (scan_counter != '1) ? scan_counter + 1'b1 : scan_counter;
  assign do_scan  = (scan_inc >= scan_limit);

  assign key_ok = key_active && ({2'b00, key_number} < 5'(KEY_COUNT));
  assign sample = key_ok ? {1'b0, key_number} : KEY_EMPTY;

  always_comb begin
    state_next        = state;
    held_key_next     = held_key;
    wait_counter_next = wait_dec;
    scan_counter_next = scan_inc;
    result.code       = EV_NONE;
    result.key        = '0;
    if (do_scan) begin
      scan_counter_next = '0;
      unique case (state)
        ST_IDLE: begin
          if (sample != KEY_EMPTY) begin
            held_key_next = sample;
            // zero debounce time reports the press on this same scan
            if (debounce_t == '0) begin
              wait_counter_next = long_t;
              state_next        = ST_PRESSED;
              result.code       = EV_PRESSED;
              result.key        = sample[KEY_W-1:0];
            end else begin
              wait_counter_next = debounce_t;
              state_next        = ST_DEBOUNCE;
            end
          end
        end
        ST_DEBOUNCE: begin
          if (held_key != sample) begin
            held_key_next = KEY_EMPTY;
            state_next    = ST_IDLE;
          end else if (wait_dec == '0) begin
            wait_counter_next = long_t;
            state_next        = ST_PRESSED;
            result.code       = EV_PRESSED;
            result.key        = held_key[KEY_W-1:0];
          end
        end
        ST_PRESSED: begin
          if (held_key != sample) begin
            state_next  = ST_IDLE;
            result.code = EV_RELEASED;
            result.key  = held_key[KEY_W-1:0];
          end else if (wait_dec == '0) begin
            wait_counter_next = hold_t;
            state_next        = ST_LONG;
            result.code       = EV_LONG_PRESSED;
            result.key        = held_key[KEY_W-1:0];
          end
        end
        ST_LONG: begin
          if (held_key != sample) begin
            state_next    = ST_IDLE;
            held_key_next = KEY_EMPTY;
            result.code   = EV_LONG_RELEASED;
            result.key    = held_key[KEY_W-1:0];
          end else if (wait_dec == '0) begin
            wait_counter_next = hold_t;
            result.code       = EV_HOLD;
            result.key        = held_key[KEY_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      held_key     <= KEY_EMPTY;
      scan_counter <= '0;
      wait_counter <= '0;
    end else if (tick) begin
      state        <= state_next;
      held_key     <= held_key_next;
      scan_counter <= scan_counter_next;
      wait_counter <= wait_counter_next;
    end
  end

  a_held_key_set: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEBOUNCE || state == ST_PRESSED || state == ST_LONG) |->
      held_key != KEY_EMPTY)
    else $error("held key empty outside idle");

  a_scan_clears: assert property (@(posedge clk) disable iff (rst)
    tick && do_scan |=> scan_counter == '0)
    else $error("scan counter not cleared after sample");

  a_press_enters: assert property (@(posedge clk) disable iff (rst)
    tick && result.code == EV_PRESSED |=> state == ST_PRESSED && wait_counter == $past(long_t))
    else $error("press event without entering pressed state");

  a_no_event_off_scan: assert property (@(posedge clk) disable iff (rst)
    !do_scan |-> result.code == EV_NONE)
    else $error("event reported on a tick without sample");

endmodule

`default_nettype wire

// ----- hdl/key_press_event_detector.sv -----
// Top level of the key press event detector: input stage, engine and result register.
//
// Usage:
//   key_in    - one request per timebase tick: key_active and key_number.
//               A key_number of KEY_COUNT or more counts as no key.
//   event_out - one result per request: event_code (0 none, 1 pressed,
//               2 released, 3 long pressed, 4 long released, 5 hold repeat)
//               and event_key. With no event, event_key is zero.
//   cfg       - register writes (0 scan_period, 1 debounce_time,
//               2 long_press_time, 3 hold_repeat_time), always ready.
//               Write only while no request is in flight.
// Timing:
//   A request is registered in the input stage and is evaluated against
//   the state machine as it moves into the result register, which drives
//   event_out. One request per cycle is sustained while event_out is ready;
//   the only state loop is the state/timer register update.
// Reset (rst, synchronous): registers take their default values, the state
//   machine goes idle, both timers clear and both stages empty.
// Stall: while event_out is not ready the result holds and the input stage
//   fills; key_in.ready drops only when both stages are full.
`default_nettype none

module key_press_event_detector
  import kped_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  kped_in_if.sink     key_in,
  kped_out_if.source  event_out,
  kped_cfg_if.sink    cfg
);

  kped_cfg_t        regs;
  kped_event_t      result;

  logic             stage_valid;
  logic             stage_active;
  logic [KEY_W-1:0] stage_number;
  logic             out_free;
  logic             tick;

  kped_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // advance the staged request whenever the result register can take it
  assign out_free     = !event_out.valid || event_out.ready;
  assign tick         = stage_valid && out_free;
  assign key_in.ready = !stage_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (key_in.ready) begin
      stage_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.ready && key_in.valid) begin
      stage_active <= key_in.key_active;
      stage_number <= key_in.key_number;
    end
  end

  kped_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .key_active (stage_active),
    .key_number (stage_number),
    .regs       (regs),
    .result     (result)
  );

  // hold the result until taken; load a new one on every tick
  always_ff @(posedge clk) begin
    if (rst) begin
      event_out.valid <= 1'b0;
    end else if (tick) begin
      event_out.valid <= 1'b1;
    end else if (event_out.ready) begin
      event_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      event_out.event_code <= result.code;
      event_out.event_key  <= result.key;
    end
  end

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !out_free |=> stage_valid)
    else $error("staged request lost while result stalled");

  a_tick_fills_out: assert property (@(posedge clk) disable iff (rst)
    tick |=> event_out.valid)
    else $error("processed request produced no result");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> key_in.ready)
    else $error("input stalled with empty stage");

endmodule

`default_nettype wire

// ----- bench/key_press_event_detector_checker.sv -----
// Event checker for the key press event detector: predicts each tick's event and compares.
module key_press_event_detector_checker
  import kped_pkg::*;
(
  input  logic clk,
  input  logic rst,
  kped_in_if   key_in,
  kped_out_if  event_out,
  kped_cfg_if  cfg,
  output int   fail_count,
  output int   pending
);

  typedef enum logic [1:0] {KEY_IDLE, KEY_DEBOUNCE, KEY_PRESSED, KEY_LONG} key_state_e;

  localparam logic [CFG_W-1:0] TIMER_TOP = '1;

  kped_cfg_t         settings;
  key_state_e        state;
  logic [HELD_W-1:0] held;
  logic [CFG_W-1:0]  scan_cnt;
  logic [CFG_W-1:0]  wait_cnt;
  kped_event_t       event_q[$];
  kped_event_t       want;
  int                results_seen;

  task automatic note_mismatch(input string msg);
    fail_count++;
    $display("mismatch: %s", msg);
  endtask

  // Advance the debounce machine by one tick and return the event it raises.
  function automatic kped_event_t decode_tick(input logic active, input logic [KEY_W-1:0] num);
    logic [HELD_W-1:0] sample;
    kped_event_t       ev;
    ev = '0;
    if (wait_cnt != 0) wait_cnt--;
    if (scan_cnt < TIMER_TOP) scan_cnt++;
    if (scan_cnt < settings.scan_period) return ev;
    scan_cnt = '0;
    sample = (active && num < KEY_COUNT) ? {1'b0, num} : KEY_EMPTY;
    case (state)
      KEY_IDLE, KEY_DEBOUNCE: begin
        if (state == KEY_IDLE && sample != KEY_EMPTY) begin
          held = sample;
          wait_cnt = settings.debounce_time;
          state = KEY_DEBOUNCE;
        end
        if (state == KEY_DEBOUNCE) begin
          if (held != sample) begin
            held = KEY_EMPTY;
            state = KEY_IDLE;
          end else if (wait_cnt == 0) begin
            wait_cnt = settings.long_press_time;
            state = KEY_PRESSED;
            ev.code = EV_PRESSED;
            ev.key = held[KEY_W-1:0];
          end
        end
      end
      KEY_PRESSED: begin
        if (held != sample) begin
          state = KEY_IDLE;
          ev.code = EV_RELEASED;
          ev.key = held[KEY_W-1:0];
        end else if (wait_cnt == 0) begin
          wait_cnt = settings.hold_repeat_time;
          state = KEY_LONG;
          ev.code = EV_LONG_PRESSED;
          ev.key = held[KEY_W-1:0];
        end
      end
      KEY_LONG: begin
        if (held != sample) begin
          state = KEY_IDLE;
          ev.code = EV_LONG_RELEASED;
          ev.key = held[KEY_W-1:0];
          held = KEY_EMPTY;
        end else if (wait_cnt == 0) begin
          wait_cnt = settings.hold_repeat_time;
          ev.code = EV_HOLD;
          ev.key = held[KEY_W-1:0];
        end
      end
      default: begin
        state = KEY_IDLE;
        held = KEY_EMPTY;
      end
    endcase
    return ev;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings.scan_period = SCAN_PERIOD_RST;
      settings.debounce_time = DEBOUNCE_TIME_RST;
      settings.long_press_time = LONG_PRESS_TIME_RST;
      settings.hold_repeat_time = HOLD_REPEAT_TIME_RST;
      state = KEY_IDLE;
      held = KEY_EMPTY;
      scan_cnt = '0;
      wait_cnt = '0;
      event_q.delete();
      results_seen = 0;
      fail_count = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SCAN_PERIOD:      settings.scan_period = cfg.data;
          REG_DEBOUNCE_TIME:    settings.debounce_time = cfg.data;
          REG_LONG_PRESS_TIME:  settings.long_press_time = cfg.data;
          REG_HOLD_REPEAT_TIME: settings.hold_repeat_time = cfg.data;
          default: ;
        endcase
      end
      if (key_in.valid && key_in.ready)
        event_q.push_back(decode_tick(key_in.key_active, key_in.key_number));
      if (event_out.valid && event_out.ready) begin
        results_seen++;
        if (event_q.size() == 0) begin
          note_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = event_q.pop_front();
          if (event_out.event_code !== want.code)
            note_mismatch($sformatf("result %0d event_code %0d, expected %0d",
                                    results_seen, event_out.event_code, want.code));
          if (event_out.event_key !== want.key)
            note_mismatch($sformatf("result %0d event_key %0d, expected %0d",
                                    results_seen, event_out.event_key, want.key));
        end
      end
    end
    pending = event_q.size();
  end

endmodule

// ----- bench/key_press_event_detector_tb.sv -----
// Testbench top of the key press event detector: clock, reset, tick and result traffic, verdict.
module key_press_event_detector_tb;
  import kped_pkg::*;

  // Worst case is far below this: ~900 ticks, each with random idle gaps on
  // either side plus pipeline latency, one long hold-off and a few drains.
  localparam int CYCLE_LIMIT = 400000;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   sent;
  int   cycles;
  bit   tx_idle;
  bit   rx_idle;
  bit   squeeze;

  kped_in_if  key_in ();
  kped_out_if event_out ();
  kped_cfg_if cfg ();

  key_press_event_detector uut (
    .clk       (clk),
    .rst       (rst),
    .key_in    (key_in),
    .event_out (event_out),
    .cfg       (cfg)
  );

  key_press_event_detector_checker chk (
    .clk        (clk),
    .rst        (rst),
    .key_in     (key_in),
    .event_out  (event_out),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one tick request and hold it until the block takes it. Valid stays
  // high on return so a back-to-back tick needs no second assignment.
  task automatic offer_tick(input logic active, input logic [KEY_W-1:0] num);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_idle = !tx_idle;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      key_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_in.valid <= 1'b1;
    key_in.key_active <= active;
    key_in.key_number <= num;
    do @(posedge clk); while (!key_in.ready);
    sent++;
  endtask

  task automatic hold_key(input logic [KEY_W-1:0] num, input int ticks);
    repeat (ticks) offer_tick(1'b1, num);
  endtask

  // Released key: the index lines still wiggle, the block must ignore them.
  task automatic no_key(input int ticks);
    repeat (ticks) offer_tick(1'b0, KEY_W'($urandom_range(0, 7)));
  endtask

  // Drop valid, wait for every expected event, then let the pipeline go quiet.
  task automatic settle();
    key_in.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
  endtask

  task automatic load_settings(input logic [CFG_W-1:0] scan_ticks, debounce_ticks,
                               long_ticks, repeat_ticks);
    write_reg(REG_SCAN_PERIOD, scan_ticks);
    write_reg(REG_DEBOUNCE_TIME, debounce_ticks);
    write_reg(REG_LONG_PRESS_TIME, long_ticks);
    write_reg(REG_HOLD_REPEAT_TIME, repeat_ticks);
    cfg.valid <= 1'b0;
  endtask

  // Mostly short times so presses, long presses and repeats all show up;
  // now and then zero or the full-scale value.
  function automatic logic [CFG_W-1:0] pick_time(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return CFG_W'($urandom_range(hi, lo));
  endfunction

  // Press-and-release sequences with random keys and lengths, a few
  // bounces inside the press, and some plain noise between them.
  task automatic play_keys(input int count);
    int stop;
    int press_len;
    int rel_len;
    logic [KEY_W-1:0] k;
    stop = sent + count;
    while (sent < stop) begin
      if ($urandom_range(0, 9) < 8) begin
        k = KEY_W'($urandom_range(0, 7));
        press_len = $urandom_range(1, 40);
        rel_len = $urandom_range(1, 12);
        repeat (press_len) begin
          if ($urandom_range(0, 19) == 0)
            offer_tick(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)));
          else
            offer_tick(1'b1, k);
        end
        no_key(rel_len);
      end else begin
        repeat ($urandom_range(1, 8))
          offer_tick(1'($urandom_range(0, 1)), KEY_W'($urandom_range(0, 7)));
      end
    end
  endtask

  // Result side: random stalls per event, with one long hold-off on request
  // so the input stage fills and ready on key_in drops.
  initial begin : result_sink
    int stall;
    event_out.ready = 1'b0;
    rx_idle = 1'b1;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_idle = !rx_idle;
      if (squeeze) begin
        squeeze = 1'b0;
        stall = SQUEEZE_CYCLES;
      end else begin
        stall = rx_idle ? $urandom_range(0, 16) : 0;
      end
      if (stall != 0) begin
        event_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      event_out.ready <= 1'b1;
      do @(posedge clk); while (!event_out.valid);
    end
  end

  initial begin : tick_source
    rst = 1'b1;
    cycles = 0;
    sent = 0;
    tx_idle = 1'b1;
    squeeze = 1'b0;
    key_in.valid = 1'b0;
    key_in.key_active = 1'b0;
    key_in.key_number = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset values: a held key must come out as pressed after scan and debounce.
    hold_key(3'd4, 40);
    no_key(15);
    settle();

    // All times zero: sample on every tick, press on first sight, long press
    // on the next scan, then a hold repeat on every scan.
    load_settings('0, '0, '0, '0);
    hold_key(3'd7, 4);
    no_key(2);
    hold_key(3'd0, 2);
    offer_tick(1'b1, 3'd3);
    no_key(1);
    settle();

    // Short times: debounce broken by another key, release from pressed,
    // debounce broken by a release, full long press with repeats.
    load_settings(16'd1, 16'd1, 16'd2, 16'd1);
    offer_tick(1'b1, 3'd2);
    offer_tick(1'b1, 3'd5);
    hold_key(3'd5, 3);
    no_key(1);
    offer_tick(1'b1, 3'd6);
    no_key(1);
    hold_key(3'd1, 6);
    no_key(1);
    settle();

    // Random phases, each with fresh register values.
    for (int phase = 0; phase < 8; phase++) begin
      load_settings(pick_time(1, 3), pick_time(0, 6), pick_time(0, 12), pick_time(1, 5));
      if (phase == 2) squeeze = 1'b1;
      play_keys(95);
      settle();
    end

    // Full-scale times: nothing gets sampled, every tick reports no event.
    load_settings('1, '1, '1, '1);
    play_keys(20);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
